// ===== hw/rtl/complex_arithmetic_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CAU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cau assertion failed");

// next-cycle implication
`define CAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cau assertion failed");

`else

`define CAU_ASSERT_NOW(label, clk, rst, ante, cons)
`define CAU_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Op codes, payload and pipeline stage types, divide saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

   typedef enum logic [1:0] {
      CAU_OP_ADD = 2'd0,
      CAU_OP_MUL = 2'd1,
      CAU_OP_DIV = 2'd2
   } cau_op_type;

   // quotient bits resolved by the divider pipe; larger quotients saturate
   localparam int DIV_QBITS = 33;
   localparam int REM_W     = 64;

   localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] a_real;
      logic signed [31:0] a_imag;
      logic signed [31:0] b_real;
      logic signed [31:0] b_imag;
   } cau_req_type;

   typedef struct packed {
      logic signed [31:0] res_real;
      logic signed [31:0] res_imag;
      logic               div_by_zero;
      logic               overflow;
   } cau_rsp_type;

   typedef struct packed {
      logic                 neg;
      logic                 big;
      logic [REM_W-1:0]     rem;
      logic [DIV_QBITS-1:0] low;
      logic [DIV_QBITS-1:0] q;
   } cau_lane_type;

   typedef struct packed {
      logic [1:0]       op;
      logic             dz;
      logic [31:0]      res_real;
      logic [31:0]      res_imag;
      logic             ovf;
      logic [REM_W-1:0] den;
      cau_lane_type     lane_r;
      cau_lane_type     lane_i;
   } cau_stage_type;

   // returns {overflow, value}
   function automatic logic [32:0] sat_div(input logic neg, input logic big,
                                           input logic [DIV_QBITS-1:0] q);
      logic        ovf;
      logic [31:0] val;
      ovf = 1'b0;
      val = q[31:0];
      if (big) begin
         ovf = 1'b1;
         val = neg ? SAT_MIN : SAT_MAX;
      end else if (!neg) begin
         if (q > 33'h0_7FFF_FFFF) begin
            ovf = 1'b1;
            val = SAT_MAX;
         end
      end else begin
         if (q > 33'h0_8000_0000) begin
            ovf = 1'b1;
            val = SAT_MIN;
         end else begin
            val = 32'd0 - q[31:0];
         end
      end
      return {ovf, val};
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cau_div_step.sv =====
// ----------------------------------------------------------------------------
// Divider step
// One restoring quotient bit per lane, one register stage with handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div_step (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   up_valid,
   output logic                   up_ready,
   input  cau_pkg::cau_stage_type up_data,
   output logic                   dn_valid,
   input  logic                   dn_ready,
   output cau_pkg::cau_stage_type dn_data
);

   function automatic cau_pkg::cau_lane_type step_lane(
      input cau_pkg::cau_lane_type       lane,
      input logic [cau_pkg::REM_W-1:0]   den
   );
      cau_pkg::cau_lane_type     r;
      logic [cau_pkg::REM_W-1:0] t;
      logic                      ge;
      r     = lane;
      t     = {lane.rem[cau_pkg::REM_W-2:0], lane.low[cau_pkg::DIV_QBITS-1]};
      ge    = (t >= den);
      r.rem = ge ? (t - den) : t;
      r.low = {lane.low[cau_pkg::DIV_QBITS-2:0], 1'b0};
      r.q   = {lane.q[cau_pkg::DIV_QBITS-2:0], ge};
      return r;
   endfunction

   logic                   valid_ff;
   cau_pkg::cau_stage_type data_ff;
   cau_pkg::cau_stage_type data_in;

   assign up_ready = ~valid_ff | dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_comb begin
      data_in        = up_data;
      data_in.lane_r = step_lane(up_data.lane_r, up_data.den);
      data_in.lane_i = step_lane(up_data.lane_i, up_data.den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, multiply and divide of signed fixed point complex operands.
// ----------------------------------------------------------------------------
//  channel | ports                          | moves
//  --------+--------------------------------+------------------------------
//  request | req_valid req_ready req_data   | op code, operands a and b
//  result  | rsp_valid rsp_ready rsp_data   | result, div_by_zero, overflow
//
//  Stages: input, products, sums, setup, 33 divider steps, output.
//  One item per cycle is sustained unless the result side stalls; the
//  depth is set by the divider pipe, which resolves one quotient bit per stage.
//  Every stage has its own valid bit and accepts when empty or draining,
//  so bubbles collapse and a stall loses nothing.
//  Synchronous reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

`include "complex_arithmetic_unit_assert.svh"

module complex_arithmetic_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cau_pkg::cau_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cau_pkg::cau_rsp_type rsp_data
);

   localparam int NW  = cau_pkg::REM_W + FRAC_BITS;
   localparam int NQ  = cau_pkg::DIV_QBITS;
   localparam int RW  = cau_pkg::REM_W;

   // returns {overflow, value}
   function automatic logic [32:0] sat_wide(input logic signed [65:0] v);
      logic signed [65:0] max_w;
      logic signed [65:0] min_w;
      max_w = 66'sh7FFF_FFFF;
      min_w = ~max_w;
      if (v > max_w) begin
         return {1'b1, cau_pkg::SAT_MAX};
      end else if (v < min_w) begin
         return {1'b1, cau_pkg::SAT_MIN};
      end
      return {1'b0, v[31:0]};
   endfunction

   function automatic cau_pkg::cau_lane_type div_setup(
      input logic signed [65:0] num,
      input logic [RW-1:0]      den
   );
      cau_pkg::cau_lane_type l;
      logic                  neg;
      logic [RW-1:0]         mag;
      logic [NW-1:0]         nf;
      logic [NW-1:0]         hi;
      neg   = num[65];
      mag   = neg ? RW'(-num) : RW'(num);
      nf    = NW'(mag) << FRAC_BITS;
      hi    = nf >> NQ;
      l.neg = neg;
      // quotient would need more bits than the pipe resolves
      l.big = (hi >= NW'(den));
      l.rem = hi[RW-1:0];
      l.low = nf[NQ-1:0];
      l.q   = '0;
      return l;
   endfunction

   // stage 1: operands
   logic                 s1_valid_ff;
   cau_pkg::cau_req_type s1_data_ff;
   logic                 s1_ready;

   // stage 2: products and add sums
   logic                 s2_valid_ff;
   logic                 s2_ready;
   logic [1:0]           s2_op_ff;
   logic signed [63:0]   p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic [63:0]          p_br2_ff, p_bi2_ff;
   logic signed [32:0]   sum_r_ff, sum_i_ff;

   // stage 3: combined terms
   logic                 s3_valid_ff;
   logic                 s3_ready;
   logic [1:0]           s3_op_ff;
   logic signed [65:0]   re_ff, im_ff, nr_ff, ni_ff;
   logic [RW-1:0]        den_ff;
   logic signed [32:0]   add_r_ff, add_i_ff;

   // stage 4 and divider pipe
   logic                   s4_valid_ff;
   logic                   s4_ready;
   cau_pkg::cau_stage_type s4_data_ff;
   cau_pkg::cau_stage_type s4_data_in;

   logic                   dv_valid [0:NQ];
   logic                   dv_ready [0:NQ];
   cau_pkg::cau_stage_type dv_data  [0:NQ];

   // output
   logic                 rsp_valid_ff;
   cau_pkg::cau_rsp_type rsp_data_ff;
   cau_pkg::cau_rsp_type rsp_data_in;
   logic                 out_ready;

   assign s1_ready  = ~s1_valid_ff | s2_ready;
   assign s2_ready  = ~s2_valid_ff | s3_ready;
   assign s3_ready  = ~s3_valid_ff | s4_ready;
   assign s4_ready  = ~s4_valid_ff | dv_ready[0];
   assign out_ready = ~rsp_valid_ff | rsp_ready;
   assign req_ready = s1_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (out_ready) begin
            rsp_valid_ff <= dv_valid[NQ];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_data_ff <= req_data;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_op_ff <= s1_data_ff.op;
         p_rr_ff  <= s1_data_ff.a_real * s1_data_ff.b_real;
         p_ii_ff  <= s1_data_ff.a_imag * s1_data_ff.b_imag;
         p_ri_ff  <= s1_data_ff.a_real * s1_data_ff.b_imag;
         p_ir_ff  <= s1_data_ff.a_imag * s1_data_ff.b_real;
         // signed squares are never negative, so the 64-bit pattern is the magnitude
         p_br2_ff <= s1_data_ff.b_real * s1_data_ff.b_real;
         p_bi2_ff <= s1_data_ff.b_imag * s1_data_ff.b_imag;
         sum_r_ff <= 33'(s1_data_ff.a_real) + 33'(s1_data_ff.b_real);
         sum_i_ff <= 33'(s1_data_ff.a_imag) + 33'(s1_data_ff.b_imag);
      end
      if (s3_ready && s2_valid_ff) begin
         s3_op_ff <= s2_op_ff;
         re_ff    <= 66'(p_rr_ff) - 66'(p_ii_ff);
         im_ff    <= 66'(p_ri_ff) + 66'(p_ir_ff);
         nr_ff    <= 66'(p_rr_ff) + 66'(p_ii_ff);
         ni_ff    <= 66'(p_ir_ff) - 66'(p_ri_ff);
         den_ff   <= p_br2_ff + p_bi2_ff;
         add_r_ff <= sum_r_ff;
         add_i_ff <= sum_i_ff;
      end
      if (s4_ready && s3_valid_ff) begin
         s4_data_ff <= s4_data_in;
      end
      if (out_ready && dv_valid[NQ]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // add and multiply finish here; divide gets its lanes set up
   always_comb begin
      logic [32:0]        sr;
      logic [32:0]        si;
      logic signed [65:0] re_sh;
      logic signed [65:0] im_sh;
      re_sh = re_ff >>> FRAC_BITS;
      im_sh = im_ff >>> FRAC_BITS;
      sr    = '0;
      si    = '0;
      case (s3_op_ff)
         cau_pkg::CAU_OP_ADD: begin
            sr = sat_wide(66'(add_r_ff));
            si = sat_wide(66'(add_i_ff));
         end
         cau_pkg::CAU_OP_MUL: begin
            sr = sat_wide(re_sh);
            si = sat_wide(im_sh);
         end
         default: begin
            sr = '0;
            si = '0;
         end
      endcase
      s4_data_in.op       = s3_op_ff;
      s4_data_in.dz       = (s3_op_ff == cau_pkg::CAU_OP_DIV) && (den_ff == '0);
      s4_data_in.res_real = sr[31:0];
      s4_data_in.res_imag = si[31:0];
      s4_data_in.ovf      = sr[32] | si[32];
      s4_data_in.den      = den_ff;
      s4_data_in.lane_r   = div_setup(nr_ff, den_ff);
      s4_data_in.lane_i   = div_setup(ni_ff, den_ff);
   end

   assign dv_valid[0] = s4_valid_ff;
   assign dv_data[0]  = s4_data_ff;
   assign dv_ready[NQ] = out_ready;

   for (genvar g = 0; g < NQ; g++) begin : g_div
      cau_div_step u_step (
         .clock    (clock),
         .reset    (reset),
         .up_valid (dv_valid[g]),
         .up_ready (dv_ready[g]),
         .up_data  (dv_data[g]),
         .dn_valid (dv_valid[g+1]),
         .dn_ready (dv_ready[g+1]),
         .dn_data  (dv_data[g+1])
      );
   end

   always_comb begin
      cau_pkg::cau_stage_type d;
      logic [32:0]            qr;
      logic [32:0]            qi;
      d  = dv_data[NQ];
      qr = cau_pkg::sat_div(d.lane_r.neg, d.lane_r.big, d.lane_r.q);
      qi = cau_pkg::sat_div(d.lane_i.neg, d.lane_i.big, d.lane_i.q);
      rsp_data_in.res_real    = d.res_real;
      rsp_data_in.res_imag    = d.res_imag;
      rsp_data_in.div_by_zero = 1'b0;
      rsp_data_in.overflow    = d.ovf;
      if (d.op == cau_pkg::CAU_OP_DIV) begin
         if (d.dz) begin
            rsp_data_in.res_real    = '0;
            rsp_data_in.res_imag    = '0;
            rsp_data_in.div_by_zero = 1'b1;
            rsp_data_in.overflow    = 1'b0;
         end else begin
            rsp_data_in.res_real = qr[31:0];
            rsp_data_in.res_imag = qi[31:0];
            rsp_data_in.overflow = qr[32] | qi[32];
         end
      end
   end

   `CAU_ASSERT_NOW(a_dz_zero, clock, reset, rsp_valid && rsp_data.div_by_zero, rsp_data.res_real == 32'sd0 && rsp_data.res_imag == 32'sd0 && !rsp_data.overflow)
   `CAU_ASSERT_NOW(a_dz_is_div, clock, reset, dv_valid[NQ] && dv_data[NQ].dz, dv_data[NQ].op == cau_pkg::CAU_OP_DIV)
   `CAU_ASSERT_NEXT(a_req_lands, clock, reset, req_valid && req_ready, s1_valid_ff)
   `CAU_ASSERT_NOW(a_ovf_sat, clock, reset, rsp_valid && rsp_data.overflow, rsp_data.res_real == cau_pkg::SAT_MAX || rsp_data.res_real == cau_pkg::SAT_MIN || rsp_data.res_imag == cau_pkg::SAT_MAX || rsp_data.res_imag == cau_pkg::SAT_MIN)

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives add, multiply, divide and unused op items through the request
// channel. Each accepted item is predicted at wide precision with floor,
// truncation and saturation applied. The prediction is compared field by
// field with the result stream, under random idling and a long receiver stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   localparam int FRAC     = 16;
   localparam int N_RANDOM = 1000;
   localparam int LIMIT    = 400000;
   localparam int DRAIN    = 60;
   // cycles with no idling on either side
   localparam int BUSY_LO  = 700;
   localparam int BUSY_HI  = 1100;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   cau_pkg::cau_req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   cau_pkg::cau_rsp_type rsp_data;

   cau_pkg::cau_req_type pending_items[$];
   cau_pkg::cau_rsp_type expected_results[$];
   int          errors;
   int          cycle_count;
   int          results_seen;
   int          hold_left;
   bit          hold_done;

   complex_arithmetic_unit #(.FRAC_BITS(FRAC)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // clamp a wide signed value to 32 bits, flagging saturation
   function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic ovf);
      if (v > 128'sh7FFF_FFFF) begin
         ovf = 1'b1;
         return cau_pkg::SAT_MAX;
      end
      if (v < -128'sh8000_0000) begin
         ovf = 1'b1;
         return cau_pkg::SAT_MIN;
      end
      return v[31:0];
   endfunction

   // (num << FRAC) / den, truncated toward zero
   function automatic logic signed [127:0] scaled_quotient(input logic signed [127:0] num,
                                                           input logic [127:0] den);
      logic [127:0] mag;
      logic [127:0] q;
      mag = num[127] ? -num : num;
      q = (mag << FRAC) / den;
      return num[127] ? -$signed(q) : $signed(q);
   endfunction

   function automatic cau_pkg::cau_rsp_type complex_result(input cau_pkg::cau_req_type item);
      cau_pkg::cau_rsp_type r;
      logic signed [127:0] ar, ai, br, bi, re, im;
      logic [127:0] den;
      logic ovf;
      ar = item.a_real;
      ai = item.a_imag;
      br = item.b_real;
      bi = item.b_imag;
      ovf = 1'b0;
      r = '0;
      case (item.op)
         cau_pkg::CAU_OP_ADD: begin
            r.res_real = clamp32(ar + br, ovf);
            r.res_imag = clamp32(ai + bi, ovf);
         end
         cau_pkg::CAU_OP_MUL: begin
            re = ar * br - ai * bi;
            im = ar * bi + ai * br;
            r.res_real = clamp32(re >>> FRAC, ovf);
            r.res_imag = clamp32(im >>> FRAC, ovf);
         end
         cau_pkg::CAU_OP_DIV: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               r.div_by_zero = 1'b1;
            end else begin
               re = ar * br + ai * bi;
               im = ai * br - ar * bi;
               r.res_real = clamp32(scaled_quotient(re, den), ovf);
               r.res_imag = clamp32(scaled_quotient(im, den), ovf);
            end
         end
         default: ;
      endcase
      r.overflow = ovf;
      return r;
   endfunction

   function automatic logic [31:0] pick_operand();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0: v = cau_pkg::SAT_MAX;
         1: v = cau_pkg::SAT_MIN;
         2: v = 32'(signed'($urandom_range(0, 4)) - 2);
         3, 4: v = $urandom();
         default: begin
            v = $urandom();
            v = {{12{v[19]}}, v[19:0]};
         end
      endcase
      return v;
   endfunction

   function automatic cau_pkg::cau_req_type make_item(input logic [1:0] op,
                                                      input logic [31:0] ar,
                                                      input logic [31:0] ai,
                                                      input logic [31:0] br,
                                                      input logic [31:0] bi);
      cau_pkg::cau_req_type it;
      it.op = op;
      it.a_real = ar;
      it.a_imag = ai;
      it.b_real = br;
      it.b_imag = bi;
      return it;
   endfunction

   // driver
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_results.push_back(complex_result(req_data));
         if (!req_valid || req_ready) begin
            if (pending_items.size() != 0 &&
                ((cycle_count > BUSY_LO && cycle_count < BUSY_HI) ||
                 $urandom_range(0, 99) >= 15)) begin
               req_valid <= 1'b1;
               req_data  <= pending_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   // monitor and receiver
   always @(posedge clock) begin
      cau_pkg::cau_rsp_type exp_r;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, actual %h", $time, rsp_data);
               errors++;
            end else begin
               exp_r = expected_results.pop_front();
               check_field("res_real", exp_r.res_real, rsp_data.res_real);
               check_field("res_imag", exp_r.res_imag, rsp_data.res_imag);
               check_field("div_by_zero", 32'(exp_r.div_by_zero), 32'(rsp_data.div_by_zero));
               check_field("overflow", 32'(exp_r.overflow), 32'(rsp_data.overflow));
            end
         end
         // one long hold-off so the pipe fills and back-pressures the sender
         if (!hold_done && results_seen == 300) begin
            hold_done <= 1'b1;
            hold_left <= 200;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (cycle_count > BUSY_LO && cycle_count < BUSY_HI) ||
                         $urandom_range(0, 99) >= 15;
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count >= LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      logic [1:0] op;
      logic [31:0] br, bi;
      errors = 0;
      cycle_count = 0;
      results_seen = 0;
      hold_left = 0;
      hold_done = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;

      // directed: extremes, every op, zero divisor, unused op
      for (int o = 0; o < 4; o++) begin
         pending_items.push_back(make_item(2'(o), cau_pkg::SAT_MAX, cau_pkg::SAT_MAX,
                                           cau_pkg::SAT_MAX, cau_pkg::SAT_MAX));
         pending_items.push_back(make_item(2'(o), cau_pkg::SAT_MIN, cau_pkg::SAT_MIN,
                                           cau_pkg::SAT_MIN, cau_pkg::SAT_MIN));
         pending_items.push_back(make_item(2'(o), cau_pkg::SAT_MAX, cau_pkg::SAT_MIN,
                                           cau_pkg::SAT_MIN, cau_pkg::SAT_MAX));
         pending_items.push_back(make_item(2'(o), 32'h0001_0000, 32'hFFFF_0000,
                                           32'h0, 32'h0));
      end
      pending_items.push_back(make_item(cau_pkg::CAU_OP_DIV, cau_pkg::SAT_MIN,
                                        cau_pkg::SAT_MAX, 32'h1, 32'h0));
      pending_items.push_back(make_item(cau_pkg::CAU_OP_DIV, 32'h0003_0000, 32'hFFFF_8000,
                                        32'h0002_0000, 32'h0001_0000));
      pending_items.push_back(make_item(cau_pkg::CAU_OP_MUL, 32'hFFFF_FFFF, 32'h0,
                                        32'h1, 32'h0));
      pending_items.push_back(make_item(cau_pkg::CAU_OP_MUL, 32'h0000_8000, 32'hFFFF_8000,
                                        32'h0001_8000, 32'h0000_4000));
      pending_items.push_back(make_item(cau_pkg::CAU_OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000,
                                        32'hFFFF_FFFF, 32'h1));

      for (int n = 0; n < N_RANDOM; n++) begin
         op = $urandom_range(0, 19) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
         br = pick_operand();
         bi = pick_operand();
         if (op == cau_pkg::CAU_OP_DIV && $urandom_range(0, 29) == 0) begin
            br = '0;
            bi = '0;
         end
         pending_items.push_back(make_item(op, pick_operand(), pick_operand(), br, bi));
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wait (pending_items.size() == 0);
      @(posedge clock);
      while (req_valid || expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/cau_pkg.sv
hw/rtl/cau_div_step.sv
hw/rtl/complex_arithmetic_unit.sv
sim/tb_top.sv
